FILE: hdl/qlfe_pkg.sv
// Package for the quartic LED fade engine: field widths, codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
package qlfe_pkg;

   // field widths
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned COLOR_W = 24;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned TICK_W  = 8;
   localparam int unsigned CHAN_W  = 8;

   // Q16 curve values run 0..65536 and need 17 bits
   localparam int unsigned Q_FRAC = 16;
   localparam int unsigned Q_W    = Q_FRAC + 1;
   localparam int unsigned PROD_W = 2 * Q_W;
   localparam logic [Q_W-1:0] Q16_ONE = Q_W'(1) << Q_FRAC;

   // divider walks one quotient bit per cycle
   localparam int unsigned DIV_STEPS = Q_FRAC;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [TICK_W-1:0] STEP_TICKS_RESET = TICK_W'(10);
   localparam logic [LEN_W-1:0]  LEN_MAX          = {LEN_W{1'b1}};

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_FADE  = 2'd1,
      CMD_FLASH = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_FADE  = 2'd1,
      MODE_FLASH = 2'd2
   } run_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SQUARE,
      ST_QUAD,
      ST_RED,
      ST_GREEN,
      ST_BLUE,
      ST_EMIT
   } ctrl_state_type;

   // operand selection of the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQUARE,
      MUL_QUAD,
      MUL_RED,
      MUL_GREEN,
      MUL_BLUE
   } mul_op_type;

   typedef struct packed {
      logic       accept;
      logic       start_div;
      logic       div_step;
      mul_op_type mul_op;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fade_go;
      logic emit_now;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/qlfe_if.sv
// Valid/ready channel interfaces for the request and response sides of
// the quartic LED fade engine. Depends on qlfe_pkg.
interface qlfe_req_if;
   logic                         valid;
   logic                         ready;
   logic [qlfe_pkg::CMD_W-1:0]   cmd;
   logic [qlfe_pkg::COLOR_W-1:0] color;
   logic [qlfe_pkg::LEN_W-1:0]   duration;
   logic                         fade_out;
   logic                         bounce;

   modport source (output valid, cmd, color, duration, fade_out, bounce, input ready);
   modport sink   (input valid, cmd, color, duration, fade_out, bounce, output ready);
endinterface

interface qlfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [qlfe_pkg::COLOR_W-1:0] led_color;
   logic                         light_on;

   modport source (output valid, led_color, light_on, input ready);
   modport sink   (input valid, led_color, light_on, output ready);
endinterface

FILE: hdl/quartic_led_fade_engine_core.sv
// Quartic LED fade engine: one request per millisecond tick or command; a
// fade step emits each colour channel scaled by p^4 (or 1 - p^4 reversed),
// with p = min(k/steps, 1) in Q16. Start-fade, idle ticks and prescaler
// ticks end in the accept state; a flash start or flash end also passes
// through the emit state, which loads the response register. A fade step
// runs: accept, 16 iterations of the restoring divider that forms p, two
// squarings and three channel products on the one shared multiplier, then
// the response load. Requests producing a result are accepted at once; the
// emit state then waits, holding off requests, while a result sits untaken.
// Depends on qlfe_pkg, qlfe_if, qlfe_ctrl and qlfe_dp.
module quartic_led_fade_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   qlfe_req_if.sink                    req_if,
   qlfe_rsp_if.source                  rsp_if,
   input  logic                        csr_we,
   input  logic [qlfe_pkg::TICK_W-1:0] csr_wdata
);
   import qlfe_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   qlfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   qlfe_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .status        (dp_status),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_cmd       (req_if.cmd),
      .req_color     (req_if.color),
      .req_duration  (req_if.duration),
      .req_fade_out  (req_if.fade_out),
      .req_bounce    (req_if.bounce),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_led_color (rsp_if.led_color),
      .rsp_light_on  (rsp_if.light_on)
   );

   // a new response appears only after a load command
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(ctrl_cmd.load_out))
      else $error("response valid rose without a load");

   // never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_out |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response register overwritten");

   // the divider starts only on an accepted request
   a_div_on_accept: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.start_div |-> (req_if.valid && req_if.ready))
      else $error("divider started without a request");

endmodule

FILE: hdl/qlfe_ctrl.sv
// Sequencer of the quartic LED fade engine: accepts requests and steps the
// datapath through divide, square and scale phases. Depends on qlfe_pkg.
module qlfe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  qlfe_pkg::dp_status_type  status,
   output qlfe_pkg::ctrl_cmd_type   cmd
);
   import qlfe_pkg::*;

   ctrl_state_type state_ff, state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decide next state and drive datapath commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.start_div = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.mul_op    = MUL_NONE;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.fade_go) begin
                  cmd.start_div = 1'b1;
                  state_in      = ST_DIVIDE;
               end else if (status.emit_now) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.mul_op = MUL_SQUARE;
            state_in   = ST_QUAD;
         end
         ST_QUAD: begin
            cmd.mul_op = MUL_QUAD;
            state_in   = ST_RED;
         end
         ST_RED: begin
            cmd.mul_op = MUL_RED;
            state_in   = ST_GREEN;
         end
         ST_GREEN: begin
            cmd.mul_op = MUL_GREEN;
            state_in   = ST_BLUE;
         end
         ST_BLUE: begin
            cmd.mul_op = MUL_BLUE;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/qlfe_dp.sv
// Datapath of the quartic LED fade engine: job state, restoring divider,
// shared multiplier and the response register. Depends on qlfe_pkg.
module qlfe_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  qlfe_pkg::ctrl_cmd_type       cmd,
   output qlfe_pkg::dp_status_type      status,
   input  logic                         csr_we,
   input  logic [qlfe_pkg::TICK_W-1:0]  csr_wdata,
   input  logic [qlfe_pkg::CMD_W-1:0]   req_cmd,
   input  logic [qlfe_pkg::COLOR_W-1:0] req_color,
   input  logic [qlfe_pkg::LEN_W-1:0]   req_duration,
   input  logic                         req_fade_out,
   input  logic                         req_bounce,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [qlfe_pkg::COLOR_W-1:0] rsp_led_color,
   output logic                         rsp_light_on
);
   import qlfe_pkg::*;

   // job state
   logic [TICK_W-1:0]  step_ticks_ff;
   run_mode_type       run_mode_ff, run_mode_in;
   logic [LEN_W-1:0]   step_count_ff, step_count_in;
   logic [TICK_W-1:0]  tick_prescale_ff, tick_prescale_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               reverse_ff, reverse_in;
   logic               bounce_ff, bounce_in;
   logic               lit_ff, lit_in;

   // work registers
   logic [LEN_W-1:0]     kk_in;
   logic                 rev_work_ff, rev_work_in;
   logic [COLOR_W-1:0]   res_color_ff, res_color_in;
   logic                 res_lit_ff, res_lit_in;
   logic [LEN_W-1:0]     rem_ff;
   logic [LEN_W-1:0]     quot_ff;
   logic                 full_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [Q_W-1:0]       p2_ff;
   logic [Q_W-1:0]       curve_ff;
   logic                 rsp_valid_ff;
   logic [COLOR_W-1:0]   out_color_ff;
   logic                 out_lit_ff;

   // decode helpers
   logic [TICK_W-1:0] period;
   logic [TICK_W-1:0] pre_inc;
   logic              step_due;
   logic [LEN_W-1:0]  cnt_inc;
   logic              len_reach;
   logic              rev_next;

   // divider and multiplier
   logic [LEN_W:0]    rem_sh;
   logic              rem_ge;
   logic [LEN_W:0]    rem_sub;
   logic [Q_W-1:0]    p_val;
   logic [Q_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    prod_q;

   // classify the request against the current job
   always_comb begin
      period    = (step_ticks_ff == '0) ? TICK_W'(1) : step_ticks_ff;
      pre_inc   = tick_prescale_ff + TICK_W'(1);
      step_due  = (pre_inc >= period);
      cnt_inc   = (step_count_ff != LEN_MAX) ? step_count_ff + LEN_W'(1) : LEN_MAX;
      len_reach = (cnt_inc >= length_ff);
      rev_next  = bounce_ff ? ~reverse_ff : reverse_ff;
      kk_in     = len_reach ? length_ff : cnt_inc;
   end

   assign status.fade_go  = (req_cmd == CMD_TICK) && (run_mode_ff == MODE_FADE) && step_due;
   assign status.emit_now = (req_cmd == CMD_FLASH)
                         || ((req_cmd == CMD_TICK) && (run_mode_ff == MODE_FLASH) && len_reach);
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // next job state for an accepted request
   always_comb begin
      run_mode_in      = run_mode_ff;
      step_count_in    = step_count_ff;
      tick_prescale_in = tick_prescale_ff;
      length_in        = length_ff;
      color_in         = color_ff;
      reverse_in       = reverse_ff;
      bounce_in        = bounce_ff;
      lit_in           = lit_ff;
      rev_work_in      = reverse_ff;
      res_color_in     = '0;
      res_lit_in       = lit_ff;
      unique case (req_cmd)
         CMD_FADE: begin
            color_in         = req_color;
            length_in        = (req_duration == '0) ? LEN_W'(1) : req_duration;
            reverse_in       = req_fade_out;
            bounce_in        = req_bounce;
            step_count_in    = '0;
            tick_prescale_in = '0;
            run_mode_in      = MODE_FADE;
         end
         CMD_FLASH: begin
            color_in         = req_color;
            length_in        = req_duration;
            step_count_in    = '0;
            tick_prescale_in = '0;
            run_mode_in      = MODE_FLASH;
            res_color_in     = req_color;
         end
         CMD_TICK: begin
            unique case (run_mode_ff)
               MODE_FLASH: begin
                  step_count_in = cnt_inc;
                  if (len_reach) begin
                     run_mode_in = MODE_IDLE;
                  end
               end
               MODE_FADE: begin
                  if (!step_due) begin
                     tick_prescale_in = pre_inc;
                  end else begin
                     tick_prescale_in = '0;
                     step_count_in    = cnt_inc;
                     if (len_reach) begin
                        if (bounce_ff) begin
                           reverse_in    = ~reverse_ff;
                           step_count_in = '0;
                           bounce_in     = 1'b0;
                        end else begin
                           run_mode_in = MODE_IDLE;
                        end
                        lit_in     = ~rev_next;
                        res_lit_in = ~rev_next;
                     end
                  end
               end
               default: begin
                  run_mode_in = MODE_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // update job state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ticks_ff    <= STEP_TICKS_RESET;
         run_mode_ff      <= MODE_IDLE;
         step_count_ff    <= '0;
         tick_prescale_ff <= '0;
         length_ff        <= LEN_W'(1);
         color_ff         <= '0;
         reverse_ff       <= 1'b0;
         bounce_ff        <= 1'b0;
         lit_ff           <= 1'b0;
      end else begin
         if (csr_we) begin
            step_ticks_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            run_mode_ff      <= run_mode_in;
            step_count_ff    <= step_count_in;
            tick_prescale_ff <= tick_prescale_in;
            length_ff        <= length_in;
            color_ff         <= color_in;
            reverse_ff       <= reverse_in;
            bounce_ff        <= bounce_in;
            lit_ff           <= lit_in;
         end
      end
   end

   // restoring divider step: p = kk * 2^16 / len, kk below len
   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      rem_ge  = (rem_sh >= {1'b0, length_ff});
      rem_sub = rem_sh - {1'b0, length_ff};
      p_val   = full_ff ? Q16_ONE : {1'b0, quot_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         rem_ff     <= kk_in;
         full_ff    <= len_reach;
         quot_ff    <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
         quot_ff    <= {quot_ff[LEN_W-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // select operands of the shared multiplier
   always_comb begin
      unique case (cmd.mul_op)
         MUL_SQUARE: begin
            mul_a = p_val;
            mul_b = p_val;
         end
         MUL_QUAD: begin
            mul_a = p2_ff;
            mul_b = p2_ff;
         end
         MUL_RED: begin
            mul_a = Q_W'(color_ff[23:16]);
            mul_b = curve_ff;
         end
         MUL_GREEN: begin
            mul_a = Q_W'(color_ff[15:8]);
            mul_b = curve_ff;
         end
         MUL_BLUE: begin
            mul_a = Q_W'(color_ff[7:0]);
            mul_b = curve_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_q = prod[Q_FRAC+Q_W-1:Q_FRAC];
   end

   // latch the work flags on accept, else capture curve terms and scaled channels
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rev_work_ff  <= rev_work_in;
         res_color_ff <= res_color_in;
         res_lit_ff   <= res_lit_in;
      end else begin
         unique case (cmd.mul_op)
            MUL_SQUARE: p2_ff    <= prod_q;
            MUL_QUAD:   curve_ff <= rev_work_ff ? Q16_ONE - prod_q : prod_q;
            MUL_RED:    res_color_ff[23:16] <= prod[Q_FRAC+CHAN_W-1:Q_FRAC];
            MUL_GREEN:  res_color_ff[15:8]  <= prod[Q_FRAC+CHAN_W-1:Q_FRAC];
            MUL_BLUE:   res_color_ff[7:0]   <= prod[Q_FRAC+CHAN_W-1:Q_FRAC];
            default: begin
            end
         endcase
      end
   end

   // response register: load a finished result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_color_ff <= res_color_ff;
         out_lit_ff   <= res_lit_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_color = out_color_ff;
   assign rsp_light_on  = out_lit_ff;

endmodule

FILE: tb/quartic_led_fade_engine_core_tb.sv
// Self-checking testbench for quartic_led_fade_engine_core: drives fade, flash
// and tick requests and checks every response against an in-bench predictor.
// Depends on qlfe_pkg, qlfe_if and the engine RTL.
module quartic_led_fade_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qlfe_pkg::*;

   // command code that the engine ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COLOR_W-1:0] color;
      logic [LEN_W-1:0]   duration;
      logic               fade_out;
      logic               bounce;
   } led_request_type;

   typedef struct packed {
      logic [COLOR_W-1:0] led_color;
      logic               light_on;
   } led_status_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [TICK_W-1:0]  csr_wdata;

   qlfe_req_if req_if();
   qlfe_rsp_if rsp_if();

   quartic_led_fade_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   run_mode_type       mode_model;
   logic [LEN_W-1:0]   step_model;
   logic [TICK_W-1:0]  prescale_model;
   logic [LEN_W-1:0]   length_model;
   logic [COLOR_W-1:0] color_model;
   logic               reverse_model;
   logic               bounce_model;
   logic               lit_model;
   logic [TICK_W-1:0]  step_ticks_model;

   led_status_type pending_status[$];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned rsp_hold_cycles;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned responses_seen;
   int unsigned settings_used;

   // clock: 1 ns low, 1 ns high
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // quartic curve applied to the stored color at step k
   function automatic logic [COLOR_W-1:0] fade_curve_color(input logic [LEN_W-1:0] k);
      longint unsigned len;
      longint unsigned kk;
      longint unsigned p;
      longint unsigned p2;
      longint unsigned curve;
      logic [COLOR_W-1:0] col;
      len = (length_model != 0) ? 64'(length_model) : 64'd1;
      kk = (64'(k) > len) ? len : 64'(k);
      p = (kk << Q_FRAC) / len;
      p2 = (p * p) >> Q_FRAC;
      curve = (p2 * p2) >> Q_FRAC;
      if (reverse_model) begin
         curve = 64'(Q16_ONE) - curve;
      end
      for (int i = 0; i < 3; i++) begin
         col[i*CHAN_W +: CHAN_W] = CHAN_W'((64'(color_model[i*CHAN_W +: CHAN_W]) * curve)
                                          >> Q_FRAC);
      end
      return col;
   endfunction

   // advance the predictor by one request; return 1 when a response follows
   function automatic bit predict_led_output(input led_request_type rq,
                                             output led_status_type res);
      logic [TICK_W:0] period;
      res = '0;
      case (rq.cmd)
         CMD_FADE: begin
            color_model = rq.color;
            length_model = (rq.duration != 0) ? rq.duration : LEN_W'(1);
            reverse_model = rq.fade_out;
            bounce_model = rq.bounce;
            step_model = '0;
            prescale_model = '0;
            mode_model = MODE_FADE;
            return 1'b0;
         end
         CMD_FLASH: begin
            color_model = rq.color;
            length_model = rq.duration;
            step_model = '0;
            prescale_model = '0;
            mode_model = MODE_FLASH;
            res.led_color = rq.color;
            res.light_on = lit_model;
            return 1'b1;
         end
         CMD_TICK: begin
            if (mode_model == MODE_FLASH) begin
               step_model = (step_model != LEN_MAX) ? step_model + 1'b1 : LEN_MAX;
               if (step_model >= length_model) begin
                  mode_model = MODE_IDLE;
                  res.light_on = lit_model;
                  return 1'b1;
               end
               return 1'b0;
            end
            if (mode_model == MODE_FADE) begin
               period = (step_ticks_model != 0) ? {1'b0, step_ticks_model} : (TICK_W+1)'(1);
               prescale_model = prescale_model + 1'b1;
               if ({1'b0, prescale_model} < period) begin
                  return 1'b0;
               end
               prescale_model = '0;
               step_model = (step_model != LEN_MAX) ? step_model + 1'b1 : LEN_MAX;
               res.led_color = fade_curve_color(step_model);
               if (step_model >= length_model) begin
                  if (bounce_model) begin
                     reverse_model = ~reverse_model;
                     step_model = '0;
                     bounce_model = 1'b0;
                  end else begin
                     mode_model = MODE_IDLE;
                  end
                  lit_model = ~reverse_model;
               end
               res.light_on = lit_model;
               return 1'b1;
            end
            mode_model = MODE_IDLE;
            return 1'b0;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic led_request_type make_request(input logic [CMD_W-1:0] cmd,
                                                    input logic [COLOR_W-1:0] color,
                                                    input logic [LEN_W-1:0] duration,
                                                    input logic fade_out,
                                                    input logic bounce);
      led_request_type rq;
      rq.cmd = cmd;
      rq.color = color;
      rq.duration = duration;
      rq.fade_out = fade_out;
      rq.bounce = bounce;
      return rq;
   endfunction

   // mostly ticks; fades and flashes mostly short, sometimes full width; now and then the ignored code
   function automatic led_request_type random_request(input int unsigned tick_pct);
      led_request_type rq;
      int unsigned pick;
      rq.color = COLOR_W'($urandom);
      rq.duration = LEN_W'($urandom);
      rq.fade_out = 1'($urandom);
      rq.bounce = 1'($urandom);
      if ($urandom_range(99) < tick_pct) begin
         rq.cmd = CMD_TICK;
      end else begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            rq.cmd = CMD_FADE;
            if ($urandom_range(9) != 0) rq.duration = LEN_W'($urandom_range(6));
         end else if (pick < 85) begin
            rq.cmd = CMD_FLASH;
            if ($urandom_range(9) != 0) rq.duration = LEN_W'($urandom_range(8));
         end else begin
            rq.cmd = CMD_UNUSED;
         end
      end
      return rq;
   endfunction

   // offer one request after a random gap; return just after it is taken
   task automatic send_request(input led_request_type rq);
      led_status_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.cmd      <= rq.cmd;
      req_if.color    <= rq.color;
      req_if.duration <= rq.duration;
      req_if.fade_out <= rq.fade_out;
      req_if.bounce   <= rq.bounce;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      if (predict_led_output(rq, res)) begin
         pending_status.push_back(res);
      end
      requests_sent++;
   endtask

   // drop valid, wait for all responses, then let the engine settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step_ticks(input logic [TICK_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      step_ticks_model = value;
      settings_used++;
   endtask

   // a tick while idle, the ignored code, a flash of length zero and the tick that ends it
   task automatic test_idle_requests();
      send_request(make_request(CMD_TICK, 24'h000000, 16'h0000, 1'b0, 1'b0));
      send_request(make_request(CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1));
      send_request(make_request(CMD_FLASH, 24'hFFFFFF, 16'h0000, 1'b1, 1'b1));
      send_request(make_request(CMD_TICK, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1));
   endtask

   // one step per tick: full curve, zero length, reverse, bounce, longest fade
   task automatic test_fade_curve();
      write_step_ticks(TICK_W'(1));
      send_request(make_request(CMD_FADE, 24'hFFFFFF, 16'd1, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 24'h000000, 16'd0, 1'b0, 1'b0));
      send_request(make_request(CMD_FADE, 24'h123456, 16'd0, 1'b1, 1'b1));
      repeat (2) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
      send_request(make_request(CMD_FADE, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0));
      repeat (2) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
      send_request(make_request(CMD_FADE, 24'hC0FF03, 16'd2, 1'b0, 1'b1));
      repeat (4) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
   endtask

   // flash end timing, longest flash replaced by a fade
   task automatic test_flash_timing();
      send_request(make_request(CMD_FLASH, 24'hA5C3E7, 16'd2, 1'b0, 1'b0));
      repeat (2) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
      send_request(make_request(CMD_FLASH, 24'h5A3C18, 16'hFFFF, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
      send_request(make_request(CMD_FADE, 24'h80FF01, 16'd1, 1'b0, 1'b0));
      send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
   endtask

   // a zero setting behaves as one step per tick
   task automatic test_zero_step_ticks();
      write_step_ticks(TICK_W'(0));
      send_request(make_request(CMD_FADE, 24'h7F8001, 16'd2, 1'b1, 1'b1));
      repeat (2) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
   endtask

   // hold the response side for a long stretch while ticks keep coming
   task automatic test_backpressure();
      write_step_ticks(TICK_W'(1));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(make_request(CMD_FADE, COLOR_W'($urandom), 16'd200, 1'b0, 1'b1));
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (40) send_request(make_request(CMD_TICK, 24'h0, 16'd0, 1'b0, 1'b0));
   endtask

   // random phases over several settings and the three idling patterns
   task automatic test_random_traffic();
      logic [TICK_W-1:0] setting [6];
      int unsigned count;
      int unsigned tick_pct;
      setting = '{TICK_W'(2), TICK_W'(1), TICK_W'(0), TICK_W'(3),
                  TICK_W'($urandom_range(4, 12)), TICK_W'(255)};
      for (int ph = 0; ph < 6; ph++) begin
         write_step_ticks(setting[ph]);
         case (ph / 2)
            0: begin send_idle_pct = 31; recv_idle_pct = 69; end
            1: begin send_idle_pct = 69; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // the slowest setting needs a long run of ticks to reach a step
         count = (setting[ph] == TICK_W'(255)) ? 300 : 130;
         tick_pct = (setting[ph] == TICK_W'(255)) ? 99 : 80;
         if (setting[ph] == TICK_W'(255)) begin
            send_request(make_request(CMD_FADE, COLOR_W'($urandom), 16'd1, 1'b0, 1'b0));
         end
         repeat (count) send_request(random_request(tick_pct));
      end
   endtask

   // response ready, with random idling and an optional long hold
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each response taken at the next edge with the oldest expectation
   always @(negedge clock) begin
      led_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         responses_seen++;
         if (pending_status.size() == 0) begin
            $display("%0t: response with nothing pending: led_color %h light_on %b",
                     $time, rsp_if.led_color, rsp_if.light_on);
            error_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_if.led_color !== want.led_color) begin
               $display("%0t: led_color expected %h actual %h",
                        $time, want.led_color, rsp_if.led_color);
               error_count++;
            end
            if (rsp_if.light_on !== want.light_on) begin
               $display("%0t: light_on expected %b actual %b",
                        $time, want.light_on, rsp_if.light_on);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d responses pending", $time, pending_status.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      error_count = 0;
      requests_sent = 0;
      responses_seen = 0;
      settings_used = 0;
      rsp_hold_cycles = 0;
      send_idle_pct = 31;
      recv_idle_pct = 69;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      req_if.valid    <= 1'b0;
      req_if.cmd      <= CMD_TICK;
      req_if.color    <= '0;
      req_if.duration <= '0;
      req_if.fade_out <= 1'b0;
      req_if.bounce   <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // predictor starts from the reset state
      mode_model = MODE_IDLE;
      step_model = '0;
      prescale_model = '0;
      length_model = LEN_W'(1);
      color_model = '0;
      reverse_model = 1'b0;
      bounce_model = 1'b0;
      lit_model = 1'b0;
      step_ticks_model = STEP_TICKS_RESET;
      repeat (2) @(posedge clock);

      test_idle_requests();
      test_fade_curve();
      test_flash_timing();
      test_zero_step_ticks();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      if (pending_status.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_status.size());
         error_count++;
      end
      $display("Sent %0d requests (ticks, fades, flashes, ignored codes) over %0d step settings,",
               requests_sent, settings_used);
      $display("checked %0d responses, including a long response-side hold.", responses_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/qlfe_pkg.sv
hdl/qlfe_if.sv
hdl/qlfe_ctrl.sv
hdl/qlfe_dp.sv
hdl/quartic_led_fade_engine_core.sv
tb/quartic_led_fade_engine_core_tb.sv
